### hw/rtl/u8dec_pkg.sv
// Shared types and constants for the UTF-8 code point decoder.
// No dependencies; used by u8dec_step and utf8_code_point_decoder.
package u8dec_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 3;
  localparam int unsigned LeftW  = 2;

  // Result status codes.
  localparam logic [StatW-1:0] ST_OK        = 2'd0;
  localparam logic [StatW-1:0] ST_BAD_START = 2'd1;
  localparam logic [StatW-1:0] ST_BAD_CONT  = 2'd2;

  // Lead bytes that carry extra bounds on the first continuation word.
  localparam logic [ByteW-1:0] LEAD_E0     = 8'hE0;
  localparam logic [ByteW-1:0] LEAD_F0     = 8'hF0;
  localparam logic [ByteW-1:0] LEAD_F4     = 8'hF4;
  localparam logic [ByteW-1:0] E0_MIN_CONT = 8'hA0;
  localparam logic [ByteW-1:0] F0_MIN_CONT = 8'h90;
  localparam logic [ByteW-1:0] F4_MAX_CONT = 8'h8F;

  // Decoder state carried from one word to the next.
  typedef struct packed {
    logic [LeftW-1:0]  bytes_left;
    logic [CountW-1:0] seq_length;
    logic [CpW-1:0]    accumulator;
    logic [ByteW-1:0]  lead_value;
    logic              seq_error;
  } u8dec_state_t;

  // One decoded character.
  typedef struct packed {
    logic              valid;
    logic [CpW-1:0]    code_point;
    logic [StatW-1:0]  status;
    logic [CountW-1:0] byte_count;
  } u8dec_res_t;

endpackage

### hw/rtl/u8dec_step.sv
// One-word update of the UTF-8 decoder state: lead decode, continuation
// checks and accumulation. Depends on u8dec_pkg.
module u8dec_step import u8dec_pkg::*; (
  input  u8dec_state_t     state_cur,
  input  logic [ByteW-1:0] data_byte,
  output u8dec_state_t     state_nxt,
  output u8dec_res_t       res
);

  logic [CpW-1:0]    acc_shift;
  logic [LeftW-1:0]  left_dec;
  logic              first_cont;
  logic              err;

  assign acc_shift  = {state_cur.accumulator[CpW-7:0], data_byte[5:0]};
  assign left_dec   = state_cur.bytes_left - LeftW'(1);
  assign first_cont = ({1'b0, state_cur.bytes_left} + CountW'(1)) == state_cur.seq_length;

  always_comb begin
    err = state_cur.seq_error || (data_byte[7:6] != 2'b10);
    if (first_cont) begin
      if (state_cur.lead_value == LEAD_E0 && data_byte < E0_MIN_CONT) err = 1'b1;
      if (state_cur.lead_value == LEAD_F0 && data_byte < F0_MIN_CONT) err = 1'b1;
      if (state_cur.lead_value == LEAD_F4 && data_byte > F4_MAX_CONT) err = 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_cur;
    res.valid      = 1'b0;
    res.code_point = '0;
    res.status     = ST_OK;
    res.byte_count = CountW'(1);
    if (state_cur.bytes_left == '0) begin
      if (data_byte[7] == 1'b0) begin
        res.valid      = 1'b1;
        res.code_point = CpW'(data_byte);
      end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
        state_nxt.seq_length  = CountW'(2);
        state_nxt.bytes_left  = LeftW'(1);
        state_nxt.accumulator = CpW'(data_byte & 8'h1F);
        state_nxt.lead_value  = data_byte;
        state_nxt.seq_error   = 1'b0;
      end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
        state_nxt.seq_length  = CountW'(3);
        state_nxt.bytes_left  = LeftW'(2);
        state_nxt.accumulator = CpW'(data_byte & 8'h0F);
        state_nxt.lead_value  = data_byte;
        state_nxt.seq_error   = 1'b0;
      end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
        state_nxt.seq_length  = CountW'(4);
        state_nxt.bytes_left  = LeftW'(3);
        state_nxt.accumulator = CpW'(data_byte & 8'h07);
        state_nxt.lead_value  = data_byte;
        state_nxt.seq_error   = 1'b0;
      end else begin
        res.valid  = 1'b1;
        res.status = ST_BAD_START;
      end
    end else begin
      state_nxt.accumulator = acc_shift;
      state_nxt.bytes_left  = left_dec;
      if (left_dec == '0) begin
        res.valid           = 1'b1;
        res.code_point      = acc_shift;
        res.status          = err ? ST_BAD_CONT : ST_OK;
        res.byte_count      = state_cur.seq_length;
        state_nxt.seq_error = 1'b0;
      end else begin
        state_nxt.seq_error = err;
      end
    end
  end

endmodule

### hw/rtl/utf8_code_point_decoder.sv
// Top level of the UTF-8 code point decoder: input word register, decode
// state, result register. Depends on u8dec_pkg and u8dec_step.

// The decoder takes one byte of a UTF-8 stream per word on the input
// channel and gives one result word per character: the code point, a
// status (ok, invalid start byte, invalid continuation byte) and the number
// of bytes the character used. It accepts one byte every cycle for as long
// as results are taken; a byte goes through the input register and the
// decode step into the result register. A single decode step lies between
// the input register and the result register. A stalled result register
// holds the input register too, and the input channel then stops after
// one more byte. Bad sequences are consumed to their full length before
// they are reported.
module utf8_code_point_decoder import u8dec_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ByteW-1:0]  in_data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CpW-1:0]    out_code_point,
  output logic [StatW-1:0]  out_status,
  output logic [CountW-1:0] out_byte_count
);

  // Input register: one byte waiting for the decode step.
  logic             in_vld_r;
  logic [ByteW-1:0] in_byte_r;

  // Decoder state that spans the bytes of one character.
  u8dec_state_t state_r;
  u8dec_state_t state_nxt;
  u8dec_res_t   res;

  // Result register.
  logic              out_vld_r;
  logic [CpW-1:0]    cp_r;
  logic [StatW-1:0]  stat_r;
  logic [CountW-1:0] cnt_r;

  logic step_go;

  // The decode step runs whenever a byte is waiting and the result register
  // is free or drains this cycle; a byte that yields no result still advances the state.
  assign step_go  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || step_go;

  u8dec_step u_step (
    .state_cur (state_r),
    .data_byte (in_byte_r),
    .state_nxt (state_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step_go) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step_go) begin
      out_vld_r <= res.valid;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && res.valid) begin
      cp_r   <= res.code_point;
      stat_r <= res.status;
      cnt_r  <= res.byte_count;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_code_point = cp_r;
  assign out_status     = stat_r;
  assign out_byte_count = cnt_r;

`ifndef ASSERT_OFF
  // An open sequence always has a known length longer than what is left.
  a_open_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.bytes_left != '0) |->
      (state_r.seq_length >= CountW'(2) &&
       {1'b0, state_r.bytes_left} < state_r.seq_length))
    else $error("open sequence has inconsistent length");

  // An invalid start byte reports a zero code point over a single byte.
  a_bad_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_BAD_START) |->
      (out_code_point == '0 && out_byte_count == CountW'(1)))
    else $error("invalid start result carries wrong fields");

  // A good one-byte character is plain ASCII.
  a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK && out_byte_count == CountW'(1)) |->
      (out_code_point < CpW'(128)))
    else $error("one-byte character above ASCII range");

  // Every result finishes a character, so the state is back at a lead byte.
  a_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (step_go && res.valid) |=> (state_r.bytes_left == '0 && !state_r.seq_error))
    else $error("result given while a sequence is still open");
`endif

endmodule
